// ===== src/sorted_stream_merge_join_core_defines.svh =====
// assertion macros for the sorted stream merge join core
// used by the core and its head-state module; no other dependencies
`ifndef SORTED_STREAM_MERGE_JOIN_CORE_DEFINES_SVH
`define SORTED_STREAM_MERGE_JOIN_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge outside reset
`define SSMJ_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("ssmj assertion failed");

// same-cycle implication
`define SSMJ_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ssmj implication failed");

// next-cycle implication
`define SSMJ_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ssmj next-cycle implication failed");

`else

`define SSMJ_ASSERT(label, clk, rstn, prop)
`define SSMJ_ASSERT_IMP(label, clk, rstn, ante, cons)
`define SSMJ_ASSERT_NXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== src/ssmj_pkg.sv =====
// shared types and constants for the sorted stream merge join core
// no dependencies
`timescale 1ns / 1ps

package ssmj_pkg;

    // fixed field widths
    localparam int QTY_BITS     = 31;
    localparam int OUT_QTY_BITS = 32;

    // stream code carried on the source field
    localparam logic SRC_PRICE = 1'b0;

    // hint to the feeder about which stream to send next
    typedef enum logic [1:0] {
        NEXT_PRICE  = 2'd0,
        NEXT_WEIGHT = 2'd1,
        NEXT_NONE   = 2'd2
    } ssmj_next_t;

    // status that travels with each result beat
    typedef struct packed {
        logic       record_valid;
        ssmj_next_t next_source;
        logic       finished;
        logic       out_of_turn;
    } ssmj_flags_t;

endpackage

// ===== src/ssmj_heads.sv =====
// head-record state of both streams and the combinational merge decision
// depends on ssmj_pkg and sorted_stream_merge_join_core_defines.svh
`timescale 1ns / 1ps
`include "sorted_stream_merge_join_core_defines.svh"

module ssmj_heads #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             step_en,
    input  logic                             in_source,
    input  logic                             in_stream_end,
    input  logic signed [KEY_BITS-1:0]       in_key,
    input  logic [ssmj_pkg::QTY_BITS-1:0]     in_quantity,
    input  logic signed [VALUE_BITS-1:0]     in_value,
    output logic signed [KEY_BITS-1:0]       res_key,
    output logic [ssmj_pkg::OUT_QTY_BITS-1:0] res_quantity,
    output logic signed [VALUE_BITS-1:0]     res_price,
    output logic signed [VALUE_BITS-1:0]     res_weight,
    output ssmj_pkg::ssmj_flags_t            res_flags
);

    import ssmj_pkg::*;

    // head registers
    logic                          a_full_reg, a_full_next;
    logic                          b_full_reg, b_full_next;
    logic                          a_done_reg, a_done_next;
    logic                          b_done_reg, b_done_next;
    logic signed [KEY_BITS-1:0]    a_key_reg, a_key_next;
    logic signed [KEY_BITS-1:0]    b_key_reg, b_key_next;
    logic [QTY_BITS-1:0]           a_qty_reg, a_qty_next;
    logic [QTY_BITS-1:0]           b_qty_reg, b_qty_next;
    logic signed [VALUE_BITS-1:0]  a_price_reg, a_price_next;
    logic signed [VALUE_BITS-1:0]  b_weight_reg, b_weight_next;

    // state after the incoming beat is loaded, before emission
    logic a_full_ld, b_full_ld, take_a, take_b, oot;

    // load, compare, emit and derive the hint
    always_comb begin
        a_full_ld     = a_full_reg;
        b_full_ld     = b_full_reg;
        a_done_next   = a_done_reg;
        b_done_next   = b_done_reg;
        a_key_next    = a_key_reg;
        b_key_next    = b_key_reg;
        a_qty_next    = a_qty_reg;
        b_qty_next    = b_qty_reg;
        a_price_next  = a_price_reg;
        b_weight_next = b_weight_reg;
        oot           = 1'b0;

        if (in_source == SRC_PRICE) begin
            if (a_full_reg || a_done_reg) begin
                oot = 1'b1;
            end else if (in_stream_end) begin
                a_done_next = 1'b1;
            end else begin
                a_full_ld    = 1'b1;
                a_key_next   = in_key;
                a_qty_next   = in_quantity;
                a_price_next = in_value;
            end
        end else begin
            if (b_full_reg || b_done_reg) begin
                oot = 1'b1;
            end else if (in_stream_end) begin
                b_done_next = 1'b1;
            end else begin
                b_full_ld     = 1'b1;
                b_key_next    = in_key;
                b_qty_next    = in_quantity;
                b_weight_next = in_value;
            end
        end

        // pick the smaller key, both on a tie; a lone head goes once the other stream ends
        take_a = 1'b0;
        take_b = 1'b0;
        if (a_full_ld && b_full_ld) begin
            if (a_key_next < b_key_next) begin
                take_a = 1'b1;
            end else if (b_key_next < a_key_next) begin
                take_b = 1'b1;
            end else begin
                take_a = 1'b1;
                take_b = 1'b1;
            end
        end else if (a_full_ld && b_done_next) begin
            take_a = 1'b1;
        end else if (b_full_ld && a_done_next) begin
            take_b = 1'b1;
        end

        a_full_next = a_full_ld && !take_a;
        b_full_next = b_full_ld && !take_b;

        // merged record, zero when nothing is emitted
        res_key      = take_a ? a_key_next : (take_b ? b_key_next : '0);
        res_quantity = (take_a ? {1'b0, a_qty_next} : '0) + (take_b ? {1'b0, b_qty_next} : '0);
        res_price    = take_a ? a_price_next : '0;
        res_weight   = take_b ? b_weight_next : '0;

        res_flags.record_valid = take_a || take_b;
        res_flags.out_of_turn  = oot;
        res_flags.finished     = a_done_next && b_done_next && !a_full_next && !b_full_next;
        if (!a_full_next && !a_done_next) begin
            res_flags.next_source = NEXT_PRICE;
        end else if (!b_full_next && !b_done_next) begin
            res_flags.next_source = NEXT_WEIGHT;
        end else begin
            res_flags.next_source = NEXT_NONE;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_full_reg <= 1'b0;
            b_full_reg <= 1'b0;
            a_done_reg <= 1'b0;
            b_done_reg <= 1'b0;
        end else if (step_en) begin
            a_full_reg <= a_full_next;
            b_full_reg <= b_full_next;
            a_done_reg <= a_done_next;
            b_done_reg <= b_done_next;
        end
    end

    // head payload
    always_ff @(posedge aclk) begin
        if (step_en) begin
            a_key_reg    <= a_key_next;
            b_key_reg    <= b_key_next;
            a_qty_reg    <= a_qty_next;
            b_qty_reg    <= b_qty_next;
            a_price_reg  <= a_price_next;
            b_weight_reg <= b_weight_next;
        end
    end

    // both heads are never left waiting together
    `SSMJ_ASSERT(a_heads_not_both_full, aclk, aresetn, !(a_full_reg && b_full_reg))
    // a head is never left waiting once the other stream has ended
    `SSMJ_ASSERT(a_price_head_drained, aclk, aresetn, !(a_full_reg && b_done_reg))
    `SSMJ_ASSERT(a_weight_head_drained, aclk, aresetn, !(b_full_reg && a_done_reg))

endmodule

// ===== src/sorted_stream_merge_join_core.sv =====
// The result of an accepted input beat is registered and shows in the next cycle.
// Throughput: one beat per cycle while m_ready holds; the head compare and the quantity add
// finish between the head registers and the output register.
// Output register frees the input whenever the result is taken or empty.
// Reset: synchronous active-low aresetn empties both heads and end flags.
`timescale 1ns / 1ps
`include "sorted_stream_merge_join_core_defines.svh"

module sorted_stream_merge_join_core #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_source,
    input  logic                             s_stream_end,
    input  logic signed [KEY_BITS-1:0]       s_key,
    input  logic [ssmj_pkg::QTY_BITS-1:0]     s_quantity,
    input  logic signed [VALUE_BITS-1:0]     s_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_record_valid,
    output logic signed [KEY_BITS-1:0]       m_out_key,
    output logic [ssmj_pkg::OUT_QTY_BITS-1:0] m_out_quantity,
    output logic signed [VALUE_BITS-1:0]     m_out_price,
    output logic signed [VALUE_BITS-1:0]     m_out_weight,
    output logic [1:0]                       m_next_source,
    output logic                             m_finished,
    output logic                             m_out_of_turn
);

    import ssmj_pkg::*;

    logic                          accept;
    logic signed [KEY_BITS-1:0]    res_key;
    logic [OUT_QTY_BITS-1:0]       res_quantity;
    logic signed [VALUE_BITS-1:0]  res_price;
    logic signed [VALUE_BITS-1:0]  res_weight;
    ssmj_flags_t                   res_flags;

    logic                          m_valid_reg;
    logic signed [KEY_BITS-1:0]    key_reg;
    logic [OUT_QTY_BITS-1:0]       qty_reg;
    logic signed [VALUE_BITS-1:0]  price_reg;
    logic signed [VALUE_BITS-1:0]  weight_reg;
    ssmj_flags_t                   flags_reg;

    // a beat enters whenever the output register is empty or being emptied
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // head state and merge decision
    ssmj_heads #(
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_heads (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_en       (accept),
        .in_source     (s_source),
        .in_stream_end (s_stream_end),
        .in_key        (s_key),
        .in_quantity   (s_quantity),
        .in_value      (s_value),
        .res_key       (res_key),
        .res_quantity  (res_quantity),
        .res_price     (res_price),
        .res_weight    (res_weight),
        .res_flags     (res_flags)
    );

    // output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            key_reg    <= res_key;
            qty_reg    <= res_quantity;
            price_reg  <= res_price;
            weight_reg <= res_weight;
            flags_reg  <= res_flags;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_record_valid = flags_reg.record_valid;
    assign m_out_key      = key_reg;
    assign m_out_quantity = qty_reg;
    assign m_out_price    = price_reg;
    assign m_out_weight   = weight_reg;
    assign m_next_source  = flags_reg.next_source;
    assign m_finished     = flags_reg.finished;
    assign m_out_of_turn  = flags_reg.out_of_turn;

    // an accepted beat always shows up at the output next cycle
    `SSMJ_ASSERT_NXT(a_accept_loads_output, aclk, aresetn, accept, m_valid_reg)
    // a finished merge asks for no more beats
    `SSMJ_ASSERT_IMP(a_finished_no_next, aclk, aresetn, m_valid_reg && flags_reg.finished,
        flags_reg.next_source == NEXT_NONE)
    // an empty result carries a zero record
    `SSMJ_ASSERT_IMP(a_empty_result_zero, aclk, aresetn,
        m_valid_reg && !flags_reg.record_valid,
        qty_reg == '0 && price_reg == '0 && weight_reg == '0 && key_reg == '0)

endmodule
